[rtl/csi_motion_detector_assert.svh]
// assertion macros for the motion detector checker
`ifndef CSI_MOTION_DETECTOR_ASSERT_SVH
`define CSI_MOTION_DETECTOR_ASSERT_SVH

// same-cycle implication
`define CSIMD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("csimd same-cycle check failed");

// next-cycle implication
`define CSIMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("csimd next-cycle check failed");

`endif

[rtl/csimd_pkg.sv]
package csimd_pkg;

	localparam int unsigned SAMPLE_W    = 8;
	localparam int unsigned MAG_W       = 8;
	localparam int unsigned SUM_W       = 20;
	localparam int unsigned CNT_W       = 13;
	localparam int unsigned FRAME_W     = 32;
	localparam int unsigned MEAN_W      = 16;
	localparam int unsigned LEVEL_W     = 24;
	localparam int unsigned PROD_W      = 32;
	localparam int unsigned FRAC_W      = 8;
	localparam int unsigned DEC_W       = 8;
	localparam int unsigned CALIB_W     = 16;
	localparam int unsigned NOISE_W     = 15;
	localparam int unsigned GAIN_W      = 16;
	localparam int unsigned CFG_DATA_W  = 24;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned DIV_W       = 32;
	localparam int unsigned DIVISOR_W   = 13;
	localparam int unsigned DIV_REM_W   = DIVISOR_W + 1;
	localparam int unsigned DIV_STEP_W  = $clog2(DIV_W);

	localparam logic [DEC_W-1:0]   DECIMATION_RST  = 8'd20;
	localparam logic [CALIB_W-1:0] CALIBRATION_RST = 16'd100;
	localparam logic [NOISE_W-1:0] NOISE_RST       = 15'd256;
	localparam logic [GAIN_W-1:0]  GAIN_RST        = 16'd256;
	localparam logic [LEVEL_W-1:0] ALARM_RST       = 24'd1280;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DECIMATION  = 3'd0,
		REG_CALIBRATION = 3'd1,
		REG_NOISE_FLOOR = 3'd2,
		REG_SCALE_GAIN  = 3'd3,
		REG_ALARM_LEVEL = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [DEC_W-1:0]   decimation;
		logic [CALIB_W-1:0] calib_span;
		logic [NOISE_W-1:0] quiet_floor;
		logic [GAIN_W-1:0]  scale_gain;
		logic [LEVEL_W-1:0] alarm_level;
	} cfg_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_count;
		logic [SUM_W-1:0]   sum;
		logic [CNT_W-1:0]   cnt;
	} frame_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_W-1:0]     quotient;
		logic [DIV_REM_W-1:0] remainder;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_DIV,
		ST_MUL,
		ST_RES
	} back_state_t;

endpackage

[rtl/csimd_front.sv]
module csimd_front #(
	parameter int unsigned MAX_FRAME_SAMPLES = 512
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [csimd_pkg::SAMPLE_W-1:0]   sample,
	input  logic                                    last_in_frame,
	input  logic                                    q_full,
	output logic                                    push,
	output csimd_pkg::frame_t                       push_data
);

	localparam logic [csimd_pkg::CNT_W-1:0] MaxCnt = csimd_pkg::CNT_W'(MAX_FRAME_SAMPLES);

	logic [csimd_pkg::SUM_W-1:0]   sum_q;
	logic [csimd_pkg::CNT_W-1:0]   cnt_q;
	logic [csimd_pkg::FRAME_W-1:0] frame_q;

	logic                          accept;
	logic                          take;
	logic [csimd_pkg::MAG_W-1:0]   mag;
	logic [csimd_pkg::SUM_W-1:0]   sum_nxt;
	logic [csimd_pkg::CNT_W-1:0]   cnt_nxt;
	logic [csimd_pkg::FRAME_W-1:0] frame_nxt;

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign take      = accept && (cnt_q < MaxCnt);
	assign mag       = sample[csimd_pkg::SAMPLE_W-1] ? csimd_pkg::MAG_W'(-sample)
		: csimd_pkg::MAG_W'(sample);
	assign sum_nxt   = take ? sum_q + csimd_pkg::SUM_W'(mag) : sum_q;
	assign cnt_nxt   = take ? cnt_q + csimd_pkg::CNT_W'(1) : cnt_q;
	assign frame_nxt = frame_q + csimd_pkg::FRAME_W'(1);

	assign push                  = accept && last_in_frame;
	assign push_data.frame_count = frame_nxt;
	assign push_data.sum         = sum_nxt;
	assign push_data.cnt         = cnt_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			cnt_q   <= '0;
			frame_q <= '0;
		end else if (accept) begin
			if (last_in_frame) begin
				sum_q   <= '0;
				cnt_q   <= '0;
				frame_q <= frame_nxt;
			end else begin
				sum_q <= sum_nxt;
				cnt_q <= cnt_nxt;
			end
		end
	end

endmodule

[rtl/csimd_queue.sv]
module csimd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  csimd_pkg::frame_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output csimd_pkg::frame_t head_data
);

	csimd_pkg::frame_t                 mem_q [csimd_pkg::QUEUE_DEPTH];
	logic [csimd_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [csimd_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [csimd_pkg::QCNT_W-1:0]      count_q;

	assign full       = (count_q == csimd_pkg::QCNT_W'(csimd_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == csimd_pkg::QPTR_W'(csimd_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + csimd_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == csimd_pkg::QPTR_W'(csimd_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + csimd_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + csimd_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - csimd_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

[rtl/csimd_div.sv]
module csimd_div (
	input  logic                clk,
	input  logic                arst_n,
	input  csimd_pkg::div_req_t req,
	output csimd_pkg::div_rsp_t rsp
);

	logic [csimd_pkg::DIV_REM_W-1:0]  rem_q;
	logic [csimd_pkg::DIV_W-1:0]      quo_q;
	logic [csimd_pkg::DIVISOR_W-1:0]  dvs_q;
	logic [csimd_pkg::DIV_STEP_W-1:0] step_q;
	logic                             busy_q;
	logic                             done_q;

	logic [csimd_pkg::DIV_REM_W-1:0]  trial;
	logic [csimd_pkg::DIV_REM_W-1:0]  dvs_ext;
	logic                             ge;
	logic [csimd_pkg::DIV_REM_W-1:0]  rem_nxt;

	assign trial   = {rem_q[csimd_pkg::DIVISOR_W-1:0], quo_q[csimd_pkg::DIV_W-1]};
	assign dvs_ext = {1'b0, dvs_q};
	assign ge      = (trial >= dvs_ext);
	assign rem_nxt = ge ? trial - dvs_ext : trial;

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[csimd_pkg::DIV_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			step_q <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			step_q <= step_q + csimd_pkg::DIV_STEP_W'(1);
			if (step_q == {csimd_pkg::DIV_STEP_W{1'b1}}) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

[rtl/csimd_back.sv]
module csimd_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  csimd_pkg::cfg_t                     cfg,
	input  logic                                head_valid,
	input  csimd_pkg::frame_t                   head_data,
	output logic                                pop,
	output csimd_pkg::div_req_t                 div_req,
	input  csimd_pkg::div_rsp_t                 div_rsp,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [csimd_pkg::LEVEL_W-1:0]       motion_level,
	output logic                                motion_detected,
	output logic                                calibrating,
	output logic                                empty_frame
);

	csimd_pkg::back_state_t          state_q;
	csimd_pkg::back_state_t          state_d;
	csimd_pkg::frame_t               ent_q;
	logic [csimd_pkg::MEAN_W-1:0]    baseline_q;
	logic [csimd_pkg::MEAN_W-1:0]    motion_q;
	logic [csimd_pkg::PROD_W-1:0]    prod_q;
	logic                            res_calib_q;
	logic                            res_empty_q;
	logic                            out_valid_q;
	logic [csimd_pkg::LEVEL_W-1:0]   level_q;
	logic                            det_q;
	logic                            calib_q;
	logic                            empty_q;

	logic [csimd_pkg::DEC_W-1:0]     dec_eff;
	logic                            is_calib;
	logic [csimd_pkg::MEAN_W-1:0]    mean;
	logic [csimd_pkg::MEAN_W-1:0]    diff;
	logic [csimd_pkg::MEAN_W-1:0]    gated;
	logic [csimd_pkg::LEVEL_W-1:0]   level_w;
	logic                            load;

	assign dec_eff  = (cfg.decimation == '0) ? csimd_pkg::DEC_W'(1) : cfg.decimation;
	assign is_calib = ent_q.frame_count < csimd_pkg::FRAME_W'(cfg.calib_span);
	assign mean     = div_rsp.quotient[csimd_pkg::MEAN_W-1:0];
	assign diff     = (mean >= baseline_q) ? mean - baseline_q : baseline_q - mean;
	assign gated    = (diff < csimd_pkg::MEAN_W'(cfg.quiet_floor)) ? '0 : diff;
	assign level_w  = prod_q[csimd_pkg::PROD_W-1:csimd_pkg::FRAC_W];
	assign load     = (state_q == csimd_pkg::ST_RES) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		div_req = '0;
		case (state_q)
			csimd_pkg::ST_IDLE: begin
				if (head_valid) begin
					pop              = 1'b1;
					div_req.start    = 1'b1;
					div_req.dividend = head_data.frame_count;
					div_req.divisor  = csimd_pkg::DIVISOR_W'(dec_eff);
					state_d          = csimd_pkg::ST_MOD;
				end
			end
			csimd_pkg::ST_MOD: begin
				if (div_rsp.done) begin
					if (div_rsp.remainder != '0) begin
						state_d = csimd_pkg::ST_IDLE;
					end else if (ent_q.cnt == '0) begin
						state_d = csimd_pkg::ST_RES;
					end else begin
						div_req.start    = 1'b1;
						div_req.dividend = csimd_pkg::DIV_W'({ent_q.sum,
							{csimd_pkg::FRAC_W{1'b0}}});
						div_req.divisor  = ent_q.cnt;
						state_d          = csimd_pkg::ST_DIV;
					end
				end
			end
			csimd_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = is_calib ? csimd_pkg::ST_RES : csimd_pkg::ST_MUL;
				end
			end
			csimd_pkg::ST_MUL: begin
				state_d = csimd_pkg::ST_RES;
			end
			csimd_pkg::ST_RES: begin
				if (load) begin
					state_d = csimd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = csimd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csimd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q <= '0;
		end else if (state_q == csimd_pkg::ST_DIV && div_rsp.done && is_calib) begin
			baseline_q <= mean;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= head_data;
		end
		case (state_q)
			csimd_pkg::ST_MOD: begin
				if (div_rsp.done && div_rsp.remainder == '0 && ent_q.cnt == '0) begin
					prod_q      <= '0;
					res_empty_q <= 1'b1;
					res_calib_q <= 1'b0;
				end
			end
			csimd_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					if (is_calib) begin
						prod_q      <= '0;
						res_calib_q <= 1'b1;
						res_empty_q <= 1'b0;
					end else begin
						motion_q <= gated;
					end
				end
			end
			csimd_pkg::ST_MUL: begin
				prod_q      <= csimd_pkg::PROD_W'(motion_q * cfg.scale_gain);
				res_calib_q <= 1'b0;
				res_empty_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			level_q <= level_w;
			det_q   <= (level_w > cfg.alarm_level);
			calib_q <= res_calib_q;
			empty_q <= res_empty_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign motion_level    = level_q;
	assign motion_detected = det_q;
	assign calibrating     = calib_q;
	assign empty_frame     = empty_q;

endmodule

[rtl/csi_motion_detector.sv]
// from the transaction carrying the frame mark to its result: queue entry, 32-step modulo for
// decimation, 32-step division for the mean (not for empty frames), multiply (measuring frames)
// throughput: one sample per cycle while in_ready is high; a frame mark occupies the shared serial
// divider for the modulo (skipped frame) or the modulo and the division (processed frame), and in_ready drops
// while the two-entry frame queue is full
// reset: asynchronous, clears counters, accumulators, baseline and queue; registers to defaults
module csi_motion_detector #(
	parameter int unsigned MAX_FRAME_SAMPLES = 512
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [csimd_pkg::SAMPLE_W-1:0] sample,
	input  logic                                  last_in_frame,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [csimd_pkg::LEVEL_W-1:0]         motion_level,
	output logic                                  motion_detected,
	output logic                                  calibrating,
	output logic                                  empty_frame,
	input  logic                                  cfg_we,
	input  logic [csimd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [csimd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	csimd_pkg::cfg_t     cfg_q;
	logic                q_full;
	logic                push;
	csimd_pkg::frame_t   push_data;
	logic                pop;
	logic                head_valid;
	csimd_pkg::frame_t   head_data;
	csimd_pkg::div_req_t div_req;
	csimd_pkg::div_rsp_t div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decimation  <= csimd_pkg::DECIMATION_RST;
			cfg_q.calib_span  <= csimd_pkg::CALIBRATION_RST;
			cfg_q.quiet_floor <= csimd_pkg::NOISE_RST;
			cfg_q.scale_gain  <= csimd_pkg::GAIN_RST;
			cfg_q.alarm_level <= csimd_pkg::ALARM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				csimd_pkg::REG_DECIMATION: begin
					cfg_q.decimation <= cfg_data[csimd_pkg::DEC_W-1:0];
				end
				csimd_pkg::REG_CALIBRATION: begin
					cfg_q.calib_span <= cfg_data[csimd_pkg::CALIB_W-1:0];
				end
				csimd_pkg::REG_NOISE_FLOOR: begin
					cfg_q.quiet_floor <= cfg_data[csimd_pkg::NOISE_W-1:0];
				end
				csimd_pkg::REG_SCALE_GAIN: begin
					cfg_q.scale_gain <= cfg_data[csimd_pkg::GAIN_W-1:0];
				end
				csimd_pkg::REG_ALARM_LEVEL: begin
					cfg_q.alarm_level <= cfg_data[csimd_pkg::LEVEL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	csimd_front #(
		.MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.last_in_frame(last_in_frame),
		.q_full       (q_full),
		.push         (push),
		.push_data    (push_data)
	);

	csimd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_data (head_data)
	);

	csimd_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	csimd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.head_valid     (head_valid),
		.head_data      (head_data),
		.pop            (pop),
		.div_req        (div_req),
		.div_rsp        (div_rsp),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.motion_level   (motion_level),
		.motion_detected(motion_detected),
		.calibrating    (calibrating),
		.empty_frame    (empty_frame)
	);

endmodule

[rtl/csimd_checker.sv]
`include "csi_motion_detector_assert.svh"

module csimd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [csimd_pkg::LEVEL_W-1:0]     motion_level,
	input logic                              motion_detected,
	input logic                              calibrating,
	input logic                              empty_frame
);

	// a stalled result transaction keeps its payload
	`CSIMD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(motion_level) && $stable(motion_detected) && $stable(calibrating) && $stable(empty_frame))

	// calibrating frames report no motion
	`CSIMD_ASSERT_NOW(a_calib_quiet, clk, arst_n, out_valid && calibrating, motion_level == '0 && !motion_detected && !empty_frame)

	// empty frames report nothing else
	`CSIMD_ASSERT_NOW(a_empty_quiet, clk, arst_n, out_valid && empty_frame, motion_level == '0 && !motion_detected && !calibrating)

	// detection needs a nonzero level
	`CSIMD_ASSERT_NOW(a_detect_level, clk, arst_n, out_valid && motion_detected, motion_level != '0)

endmodule

bind csi_motion_detector csimd_checker u_checker (.*);

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam int unsigned MAX_FRAME_SAMPLES = 512;
	localparam int unsigned SETTLE_CYCLES     = 250;
	localparam int unsigned HOLD_OFF_CYCLES   = 3000;
	localparam int unsigned CYCLE_LIMIT       = 1000000;

	typedef struct packed {
		logic [csimd_pkg::LEVEL_W-1:0] level;
		logic                          detected;
		logic                          calib;
		logic                          empty;
	} motion_report_t;

	typedef enum int unsigned {
		FLAVOR_RANDOM,
		FLAVOR_EXTREME,
		FLAVOR_QUIET
	} sample_flavor_t;

	class detector_scoreboard;
		bit [csimd_pkg::DEC_W-1:0]   decimation;
		bit [csimd_pkg::CALIB_W-1:0] calib_frames;
		bit [csimd_pkg::NOISE_W-1:0] quiet_floor;
		bit [csimd_pkg::GAIN_W-1:0]  gain;
		bit [csimd_pkg::LEVEL_W-1:0] alarm;

		bit [csimd_pkg::FRAME_W-1:0] frame_cnt;
		bit [csimd_pkg::SUM_W-1:0]   mag_sum;
		bit [csimd_pkg::CNT_W-1:0]   seen;
		bit [csimd_pkg::MEAN_W-1:0]  baseline;

		motion_report_t pending_reports[$];
		int unsigned    mismatches;
		int unsigned    reports_checked;
		int unsigned    calib_seen;
		int unsigned    alarms_seen;

		function new();
			decimation   = csimd_pkg::DECIMATION_RST;
			calib_frames = csimd_pkg::CALIBRATION_RST;
			quiet_floor  = csimd_pkg::NOISE_RST;
			gain         = csimd_pkg::GAIN_RST;
			alarm        = csimd_pkg::ALARM_RST;
		endfunction

		function void note_reg_write(logic [csimd_pkg::CFG_IDX_W-1:0] idx,
				logic [csimd_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				csimd_pkg::REG_DECIMATION:  decimation   = data[csimd_pkg::DEC_W-1:0];
				csimd_pkg::REG_CALIBRATION: calib_frames = data[csimd_pkg::CALIB_W-1:0];
				csimd_pkg::REG_NOISE_FLOOR: quiet_floor  = data[csimd_pkg::NOISE_W-1:0];
				csimd_pkg::REG_SCALE_GAIN:  gain         = data[csimd_pkg::GAIN_W-1:0];
				csimd_pkg::REG_ALARM_LEVEL: alarm        = data[csimd_pkg::LEVEL_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic signed [csimd_pkg::SAMPLE_W-1:0] s, logic last);
			bit [csimd_pkg::MAG_W-1:0] mag;
			bit [31:0]                 n;
			bit [31:0]                 mean;
			bit [31:0]                 motion;
			bit [31:0]                 dec;
			bit [63:0]                 scaled;
			motion_report_t            r;
			mag = csimd_pkg::MAG_W'(s[csimd_pkg::SAMPLE_W-1] ? -int'(s) : int'(s));
			if (seen < MAX_FRAME_SAMPLES) begin
				mag_sum = mag_sum + mag;
				seen    = seen + 1'b1;
			end
			if (!last)
				return;
			frame_cnt = frame_cnt + 1;
			n = seen;
			mean = 0;
			if (n != 0)
				mean = 32'((64'(mag_sum) << csimd_pkg::FRAC_W) / n);
			mag_sum = '0;
			seen    = '0;
			dec = (decimation == 0) ? 1 : decimation;
			if (frame_cnt % dec != 0)
				return;
			r = '0;
			if (n == 0) begin
				r.empty = 1'b1;
			end else if (frame_cnt < calib_frames) begin
				baseline = mean[csimd_pkg::MEAN_W-1:0];
				r.calib  = 1'b1;
			end else begin
				motion = (mean >= baseline) ? mean - baseline : baseline - mean;
				if (motion < quiet_floor)
					motion = 0;
				scaled = (64'(motion) * gain) >> csimd_pkg::FRAC_W;
				if (scaled > {csimd_pkg::LEVEL_W{1'b1}})
					scaled = {csimd_pkg::LEVEL_W{1'b1}};
				r.level = scaled[csimd_pkg::LEVEL_W-1:0];
			end
			r.detected = r.level > alarm;
			pending_reports.push_back(r);
		endfunction

		function void check_report(logic [csimd_pkg::LEVEL_W-1:0] level, logic detected,
				logic calib, logic empty);
			motion_report_t r;
			if (pending_reports.size() == 0) begin
				$error("report with none pending: motion_level %0d", level);
				mismatches++;
				return;
			end
			r = pending_reports.pop_front();
			reports_checked++;
			if (r.calib)
				calib_seen++;
			if (r.detected)
				alarms_seen++;
			if (level !== r.level) begin
				$error("motion_level: expected %0d, got %0d", r.level, level);
				mismatches++;
			end
			if (detected !== r.detected) begin
				$error("motion_detected: expected %0b, got %0b", r.detected, detected);
				mismatches++;
			end
			if (calib !== r.calib) begin
				$error("calibrating: expected %0b, got %0b", r.calib, calib);
				mismatches++;
			end
			if (empty !== r.empty) begin
				$error("empty_frame: expected %0b, got %0b", r.empty, empty);
				mismatches++;
			end
		endfunction
	endclass

	logic                                  clk;
	logic                                  arst_n;
	logic                                  in_valid;
	logic                                  in_ready;
	logic signed [csimd_pkg::SAMPLE_W-1:0] sample;
	logic                                  last_in_frame;
	logic                                  out_valid;
	logic                                  out_ready;
	logic [csimd_pkg::LEVEL_W-1:0]         motion_level;
	logic                                  motion_detected;
	logic                                  calibrating;
	logic                                  empty_frame;
	logic                                  cfg_we;
	logic [csimd_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [csimd_pkg::CFG_DATA_W-1:0]      cfg_data;

	detector_scoreboard tracker = new();

	bit          tx_gaps       = 1'b0;
	bit          rx_stalls     = 1'b0;
	bit          hold_off_req  = 1'b0;
	int unsigned items_sent    = 0;
	int unsigned cycle_count   = 0;

	csi_motion_detector #(
		.MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample         (sample),
		.last_in_frame  (last_in_frame),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.motion_level   (motion_level),
		.motion_detected(motion_detected),
		.calibrating    (calibrating),
		.empty_frame    (empty_frame),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// transaction monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				tracker.note_reg_write(cfg_index, cfg_data);
			if (out_valid && out_ready)
				tracker.check_report(motion_level, motion_detected, calibrating, empty_frame);
			if (in_valid && in_ready)
				tracker.note_sample(sample, last_in_frame);
		end
	end

	function automatic int unsigned gap_len();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
				out_ready <= 1'b1;
			end else if (!rx_stalls || $urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				repeat (gap_len()) @(negedge clk);
			end
		end
	end

	function automatic logic signed [csimd_pkg::SAMPLE_W-1:0] pick_sample(
			sample_flavor_t flavor);
		case (flavor)
			FLAVOR_RANDOM:  return csimd_pkg::SAMPLE_W'($urandom);
			FLAVOR_EXTREME: return $urandom_range(0, 1) ? -8'sd128 : 8'sd127;
			default:        return csimd_pkg::SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
		endcase
	endfunction

	task automatic send_sample(input logic signed [csimd_pkg::SAMPLE_W-1:0] s,
			input logic last);
		int unsigned gap;
		gap = tx_gaps ? gap_len() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid      <= 1'b1;
		sample        <= s;
		last_in_frame <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_frame(input int unsigned len, input sample_flavor_t flavor);
		for (int unsigned i = 0; i < len; i++)
			send_sample(pick_sample(flavor), i == len - 1);
	endtask

	task automatic cfg_write(input logic [csimd_pkg::CFG_IDX_W-1:0] idx,
			input logic [csimd_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for every report, then for frames still in the back stage
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// junk above the width of each register narrower than cfg_data checks the masking
	task automatic apply_settings(input int unsigned dec, input int unsigned calib,
			input int unsigned noise, input int unsigned gain, input int unsigned alarm);
		cfg_write(csimd_pkg::REG_DECIMATION, {16'($urandom), 8'(dec)});
		cfg_write(csimd_pkg::REG_CALIBRATION, {8'($urandom), 16'(calib)});
		cfg_write(csimd_pkg::REG_NOISE_FLOOR, {9'($urandom), 15'(noise)});
		cfg_write(csimd_pkg::REG_SCALE_GAIN, {8'($urandom), 16'(gain)});
		cfg_write(csimd_pkg::REG_ALARM_LEVEL, 24'(alarm));
	endtask

	task automatic stream_frames(input int unsigned budget, input int unsigned max_len);
		int unsigned sent_here;
		int unsigned len;
		sent_here = 0;
		while (sent_here < budget) begin
			len = $urandom_range(1, max_len);
			send_frame(len, sample_flavor_t'($urandom_range(0, 2)));
			sent_here += len;
		end
	endtask

	initial begin
		int unsigned needed;
		in_valid      = 1'b0;
		sample        = '0;
		last_in_frame = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		arst_n        = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: calibrate on two frames, then boundary deviations
		cfg_write(csimd_pkg::REG_DECIMATION, 24'hABCD01);
		cfg_write(csimd_pkg::REG_CALIBRATION, 24'hFF0003);
		cfg_write(csimd_pkg::REG_NOISE_FLOOR, 24'hFF8000);
		cfg_write(csimd_pkg::REG_SCALE_GAIN, 24'hFF0100);
		cfg_write(csimd_pkg::REG_ALARM_LEVEL, 24'h000100);
		for (int i = int'(csimd_pkg::REG_ALARM_LEVEL) + 1; i < (1 << csimd_pkg::CFG_IDX_W);
				i++)
			cfg_write(csimd_pkg::CFG_IDX_W'(i), 24'($urandom));
		send_sample(8'sd0, 1'b1);
		send_sample(8'sd1, 1'b0);
		send_sample(-8'sd1, 1'b1);
		send_sample(-8'sd128, 1'b1);
		send_sample(8'sd127, 1'b1);
		repeat (2) send_sample(8'sd0, 1'b0);
		send_sample(8'sd0, 1'b1);
		send_sample(8'sd1, 1'b0);
		send_sample(8'sd0, 1'b0);
		send_sample(8'sd0, 1'b1);

		// full-scale registers, zero baseline, widest deviation
		settle();
		cfg_write(csimd_pkg::REG_CALIBRATION, 24'hFFFFFF);
		cfg_write(csimd_pkg::REG_NOISE_FLOOR, 24'hFFFFFF);
		cfg_write(csimd_pkg::REG_SCALE_GAIN, 24'hFFFFFF);
		cfg_write(csimd_pkg::REG_ALARM_LEVEL, 24'hFFFFFF);
		send_sample(8'sd0, 1'b1);
		settle();
		cfg_write(csimd_pkg::REG_CALIBRATION, 24'hFF0000);
		repeat (2) send_sample(-8'sd128, 1'b0);
		send_sample(-8'sd128, 1'b1);
		send_sample(-8'sd128, 1'b0);
		send_sample(8'sd127, 1'b1);
		send_sample(8'sd127, 1'b1);

		// zero decimation, back to back
		settle();
		apply_settings(0, 0, 0, 256, 0);
		stream_frames(60, 6);

		// calibration running into measurement
		settle();
		apply_settings(1, 16'(tracker.frame_cnt + 10), $urandom_range(0, 3000),
			$urandom_range(0, 65535), $urandom_range(0, 200000));
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		stream_frames(120, 8);

		// receiver holds off while short frames keep coming
		settle();
		apply_settings(1, 0, $urandom_range(0, 500), $urandom_range(128, 1024), 4000);
		tx_gaps      = 1'b0;
		rx_stalls    = 1'b0;
		hold_off_req = 1'b1;
		stream_frames(80, 3);

		// largest decimation
		settle();
		apply_settings(255, 0, 0, 256, 16384);
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		needed = 255 - int'(tracker.frame_cnt % 255) + 2;
		repeat (needed) send_frame(1, FLAVOR_RANDOM);

		// frame longer than the sample limit
		settle();
		apply_settings(1, 0, 0, $urandom_range(0, 65535), $urandom_range(0, 100000));
		send_frame($urandom_range(MAX_FRAME_SAMPLES + 1, MAX_FRAME_SAMPLES + 12),
			FLAVOR_EXTREME);
		send_frame(MAX_FRAME_SAMPLES, FLAVOR_QUIET);
		stream_frames(40, 6);

		// random settings
		settle();
		apply_settings($urandom_range(2, 10), 16'(tracker.frame_cnt + $urandom_range(0, 10)),
			$urandom_range(0, 32767), $urandom_range(0, 65535), $urandom_range(0, 16777215));
		stream_frames(100, 12);

		settle();
		$display("covered %0d samples in %0d frames, %0d reports checked",
			items_sent, tracker.frame_cnt, tracker.reports_checked);
		$display("%0d calibrating, %0d alarms; decimation from 0 to 255, full-scale registers",
			tracker.calib_seen, tracker.alarms_seen);
		if (tracker.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/csimd_pkg.sv
rtl/csimd_front.sv
rtl/csimd_queue.sv
rtl/csimd_div.sv
rtl/csimd_back.sv
rtl/csi_motion_detector.sv
rtl/csimd_checker.sv
dv/tb.sv
